>>> sv/msa_pkg.sv
package msa_pkg;

  // default configuration of the top level
  localparam int unsigned CHANNELS_DEF    = 16;
  localparam int unsigned COUNT_WIDTH_DEF = 16;

  // fixed field widths
  localparam int unsigned CH_W      = 4;
  localparam int unsigned READING_W = 16;
  localparam int unsigned AVG_W     = 16;
  localparam int unsigned SHIFT_AMT = 3;
  localparam int unsigned SAMPLE_W  = READING_W - SHIFT_AMT;

  localparam logic [AVG_W-1:0] EMPTY_RESET = 16'h4000;

  // request opcodes
  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_REPORT = 1'b1
  } op_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SMP_RD,
    ST_SMP_WR,
    ST_RPT_RD,
    ST_RPT_CHK,
    ST_RPT_DIV,
    ST_RPT_EMIT
  } state_e;

endpackage

>>> sv/multichannel_sensor_averager.sv
// Sample request: read and update states in the block, not ready meanwhile.
// Report request: per channel a read and a check, then, when the channel has samples,
// a pass through the shared serial divider, then an emit, plus any wait on the
// output register.
// Reset (async, active low) clears all sums and counts through per-entry valid
// bits at once and sets the empty code to 0x4000; no clearing pass.
module multichannel_sensor_averager #(
  parameter int unsigned CHANNELS    = msa_pkg::CHANNELS_DEF,
  parameter int unsigned COUNT_WIDTH = msa_pkg::COUNT_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         opcode_i,
  input  logic [msa_pkg::CH_W-1:0]      channel_i,
  input  logic [msa_pkg::READING_W-1:0] raw_reading_i,
  input  logic                         read_ok_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [msa_pkg::CH_W-1:0]      out_channel_o,
  output logic [msa_pkg::AVG_W-1:0]     average_o,
  output logic                         last_o,
  input  logic                         cfg_we_i,
  input  logic [msa_pkg::AVG_W-1:0]     cfg_wdata_i
);

  localparam int unsigned SUM_W = msa_pkg::SAMPLE_W + COUNT_WIDTH;
  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  msa_pkg::state_e state_q, state_d;

  logic [IDX_W-1:0]             addr_q, addr_d;
  logic [msa_pkg::SAMPLE_W-1:0] sample_q, sample_d;
  logic [msa_pkg::AVG_W-1:0]    res_q, res_d;
  logic [msa_pkg::AVG_W-1:0]    empty_code_q;

  logic                      out_valid_q, out_valid_d;
  logic                      out_load;
  logic [msa_pkg::CH_W-1:0]  out_channel_q;
  logic [msa_pkg::AVG_W-1:0] average_q;
  logic                      last_q;

  logic                   rd_en, wr_en, clr_en;
  logic [SUM_W-1:0]       wr_sum, rd_sum;
  logic [COUNT_WIDTH-1:0] wr_cnt, rd_cnt;

  logic             div_start, div_done;
  logic [SUM_W-1:0] quotient;

  logic ch_in_range;
  logic last_ch;

  assign ch_in_range = 32'(channel_i) < CHANNELS;
  assign last_ch     = addr_q == IDX_W'(CHANNELS - 1);

  msa_store #(
    .CHANNELS    (CHANNELS),
    .SUM_W       (SUM_W),
    .COUNT_WIDTH (COUNT_WIDTH),
    .IDX_W       (IDX_W)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .addr_i   (addr_q),
    .rd_en_i  (rd_en),
    .wr_en_i  (wr_en),
    .clr_en_i (clr_en),
    .wr_sum_i (wr_sum),
    .wr_cnt_i (wr_cnt),
    .rd_sum_o (rd_sum),
    .rd_cnt_o (rd_cnt)
  );

  msa_divider #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (COUNT_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rd_sum),
    .divisor_i  (rd_cnt),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // updated entry for a sample
  assign wr_sum = SUM_W'(rd_sum + SUM_W'(sample_q));
  assign wr_cnt = COUNT_WIDTH'(rd_cnt + 1'b1);

  // sequencer
  always_comb begin
    state_d    = state_q;
    addr_d     = addr_q;
    sample_d   = sample_q;
    res_d      = res_q;
    in_ready_o = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    clr_en     = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      msa_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (opcode_i == msa_pkg::OP_REPORT) begin
            addr_d  = '0;
            state_d = msa_pkg::ST_RPT_RD;
          end else if (read_ok_i && ch_in_range) begin
            addr_d   = IDX_W'(channel_i);
            sample_d = raw_reading_i[msa_pkg::READING_W-1:msa_pkg::SHIFT_AMT];
            state_d  = msa_pkg::ST_SMP_RD;
          end
        end
      end
      msa_pkg::ST_SMP_RD: begin
        rd_en   = 1'b1;
        state_d = msa_pkg::ST_SMP_WR;
      end
      msa_pkg::ST_SMP_WR: begin
        // a full count drops the sample
        wr_en   = ~&rd_cnt;
        state_d = msa_pkg::ST_IDLE;
      end
      msa_pkg::ST_RPT_RD: begin
        rd_en   = 1'b1;
        state_d = msa_pkg::ST_RPT_CHK;
      end
      msa_pkg::ST_RPT_CHK: begin
        clr_en = 1'b1;
        if (rd_cnt == '0) begin
          res_d   = empty_code_q;
          state_d = msa_pkg::ST_RPT_EMIT;
        end else begin
          div_start = 1'b1;
          state_d   = msa_pkg::ST_RPT_DIV;
        end
      end
      msa_pkg::ST_RPT_DIV: begin
        if (div_done) begin
          res_d   = quotient[msa_pkg::AVG_W-1:0];
          state_d = msa_pkg::ST_RPT_EMIT;
        end
      end
      msa_pkg::ST_RPT_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          if (last_ch) begin
            state_d = msa_pkg::ST_IDLE;
          end else begin
            addr_d  = addr_q + 1'b1;
            state_d = msa_pkg::ST_RPT_RD;
          end
        end
      end
      default: begin
        state_d = msa_pkg::ST_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= msa_pkg::ST_IDLE;
      out_valid_q  <= 1'b0;
      addr_q       <= '0;
      empty_code_q <= msa_pkg::EMPTY_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      addr_q      <= addr_d;
      if (cfg_we_i) begin
        empty_code_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    res_q    <= res_d;
    if (out_load) begin
      out_channel_q <= msa_pkg::CH_W'(addr_q);
      average_q     <= res_q;
      last_q        <= last_ch;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_channel_q;
  assign average_o     = average_q;
  assign last_o        = last_q;

endmodule

>>> sv/msa_divider.sv
// Restoring divider, one quotient bit per cycle.
module msa_divider #(
  parameter int unsigned DIVIDEND_W = 29,
  parameter int unsigned DIVISOR_W  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dvsr_q, dvsr_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;

  logic [DIVISOR_W:0] shifted;
  logic [DIVISOR_W:0] diff;

  // one trial subtraction per step
  always_comb begin
    shifted = {rem_q, quo_q[DIVIDEND_W-1]};
    diff    = shifted - {1'b0, dvsr_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    dvsr_d  = dvsr_q;
    quo_d   = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIVIDEND_W);
      rem_d  = '0;
      dvsr_d = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      if (!diff[DIVISOR_W]) begin
        rem_d = diff[DIVISOR_W-1:0];
        quo_d = {quo_q[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[DIVISOR_W-1:0];
        quo_d = {quo_q[DIVIDEND_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvsr_q <= dvsr_d;
    quo_q  <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> sv/msa_store.sv
// Per-channel sum/count memory with a valid bit per entry.
// An entry that is not valid reads as zero sum and zero count.
module msa_store #(
  parameter int unsigned CHANNELS    = 16,
  parameter int unsigned SUM_W       = 29,
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned IDX_W       = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [IDX_W-1:0]       addr_i,
  input  logic                   rd_en_i,
  input  logic                   wr_en_i,
  input  logic                   clr_en_i,
  input  logic [SUM_W-1:0]       wr_sum_i,
  input  logic [COUNT_WIDTH-1:0] wr_cnt_i,
  output logic [SUM_W-1:0]       rd_sum_o,
  output logic [COUNT_WIDTH-1:0] rd_cnt_o
);

  logic [SUM_W+COUNT_WIDTH-1:0] mem [CHANNELS];
  logic [SUM_W+COUNT_WIDTH-1:0] rdata_q;
  logic [CHANNELS-1:0]          valid_q;
  logic                         rvalid_q;

  // memory array: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[addr_i] <= {wr_sum_i, wr_cnt_i};
    end
    if (rd_en_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  // valid bits: set on write, cleared as a report drains each entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[addr_i] <= 1'b1;
      end else if (clr_en_i) begin
        valid_q[addr_i] <= 1'b0;
      end
      if (rd_en_i) begin
        rvalid_q <= valid_q[addr_i];
      end
    end
  end

  assign rd_sum_o = rvalid_q ? rdata_q[SUM_W+COUNT_WIDTH-1:COUNT_WIDTH] : '0;
  assign rd_cnt_o = rvalid_q ? rdata_q[COUNT_WIDTH-1:0] : '0;

endmodule
